// ----- hdl/terrace_curve_mapper_core_defines.svh -----
// assertion macros for the terrace curve mapper
`ifndef TERRACE_CURVE_MAPPER_CORE_DEFINES_SVH
`define TERRACE_CURVE_MAPPER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TCM_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tcm assertion failed");

// next-cycle implication, disabled while reset is low
`define TCM_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tcm assertion failed");

`endif

// ----- hdl/tcm_pkg.sv -----
// shared types and constants of the terrace curve mapper
`default_nettype none

package tcm_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int VALUE_BITS_DEF = 16;
  localparam int ALPHA_BITS     = 16;
  localparam int KIND_BITS      = 2;
  localparam int STATUS_BITS    = 2;
  localparam int HELD_BITS      = 5;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_EVAL  = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK   = 2'd0,
    STAT_FEW  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_DUP  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WR,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/tcm_channels.sv -----
// valid/ready channel interfaces for items and results
`default_nettype none

interface tcm_in_if #(
  parameter int VALUE_BITS = tcm_pkg::VALUE_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic [tcm_pkg::KIND_BITS-1:0]      kind;
  logic signed [VALUE_BITS-1:0]       sample;
  logic signed [VALUE_BITS-1:0]       point_value;

  modport source (output valid, kind, sample, point_value, input ready);
  modport sink   (input valid, kind, sample, point_value, output ready);
endinterface

interface tcm_out_if #(
  parameter int VALUE_BITS = tcm_pkg::VALUE_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [VALUE_BITS-1:0]       mapped_value;
  logic [tcm_pkg::STATUS_BITS-1:0]    status;
  logic [tcm_pkg::HELD_BITS-1:0]      points_held;

  modport source (output valid, mapped_value, status, points_held, input ready);
  modport sink   (input valid, mapped_value, status, points_held, output ready);
endinterface

`default_nettype wire

// ----- hdl/tcm_point_ram.sv -----
// control point table, one write and one registered read port
`default_nettype none

module tcm_point_ram #(
  parameter int DEPTH = tcm_pkg::MAX_POINTS_DEF,
  parameter int WIDTH = tcm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic signed [WIDTH-1:0]    wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic signed [WIDTH-1:0]         rd_data
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tcm_divider.sv -----
// restoring divider, one quotient bit per cycle, numerator below denominator
`default_nettype none

module tcm_divider #(
  parameter int VALUE_BITS = tcm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start_i,
  input  wire logic [VALUE_BITS-1:0]           numer_i,
  input  wire logic [VALUE_BITS-1:0]           denom_i,
  output logic                                 done_o,
  output logic [tcm_pkg::ALPHA_BITS-1:0]       quot_o
);

  localparam int QB = tcm_pkg::ALPHA_BITS;
  localparam int SW = $clog2(QB + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] den_r, den_nxt;
  logic [QB-1:0]         quot_r, quot_nxt;
  logic [VALUE_BITS:0]   rem_sh;
  logic [VALUE_BITS:0]   rem_diff;
  logic                  fits;

  assign rem_sh   = {rem_r, 1'b0};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign fits     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      step_nxt = SW'(QB);
      rem_nxt  = numer_i;
      den_nxt  = denom_i;
    end else if (busy_r) begin
      rem_nxt  = fits ? rem_diff[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
      quot_nxt = {quot_r[QB-2:0], fits};
      step_nxt = step_r - SW'(1);
      if (step_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done_o = done_r;
  assign quot_o = quot_r;

endmodule

`default_nettype wire

// ----- hdl/tcm_scaler.sv -----
// squares the blend factor and scales the span, two registered stages
`default_nettype none

module tcm_scaler #(
  parameter int VALUE_BITS = tcm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start_i,
  input  wire logic [tcm_pkg::ALPHA_BITS:0]  alpha_i,
  input  wire logic [VALUE_BITS-1:0]         span_i,
  output logic                               done_o,
  output logic [VALUE_BITS-1:0]              mag_o
);

  localparam int AF = tcm_pkg::ALPHA_BITS;
  localparam int PW = VALUE_BITS + AF + 1;
  localparam logic [PW-1:0] ROUND = PW'(1) << (AF - 1);

  logic                  v1_r, v2_r;
  logic [AF:0]           a2_r;
  logic [VALUE_BITS-1:0] span_r;
  logic [PW-1:0]         prod_r;
  logic [2*AF+1:0]       sq;
  logic [PW-1:0]         prod;

  assign sq   = alpha_i * alpha_i;
  assign prod = span_r * a2_r + ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a2_r   <= sq[2*AF:AF];
    span_r <= span_i;
    prod_r <= prod;
  end

  assign done_o = v2_r;
  assign mag_o  = prod_r[VALUE_BITS+AF-1:AF];

endmodule

`default_nettype wire

// ----- hdl/terrace_curve_mapper_core.sv -----
// top level: item sequencer around the point table, divider and scaler
// path from accept to result valid: clear, unused kind, full table and too few points go
//   straight to the result; add runs a check pass, then a shift pass and a write (an empty
//   table is written at once); duplicate ends the check pass; evaluate scans the table and,
//   when the sample lies between two points, runs the serial divide and 2 multiply stages
// throughput: one item at a time; the next item is taken while a result waits
//   in the output register, the table scans and the serial divider set the rate
// reset: point count and invert mode cleared, table contents undefined until written
`default_nettype none

`include "terrace_curve_mapper_core_defines.svh"

module terrace_curve_mapper_core #(
  parameter int MAX_POINTS = tcm_pkg::MAX_POINTS_DEF,
  parameter int VALUE_BITS = tcm_pkg::VALUE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcm_in_if.sink     in_ch,
  tcm_out_if.source  out_ch,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int VB = VALUE_BITS;
  localparam int AF = tcm_pkg::ALPHA_BITS;
  localparam logic [AF:0] ALPHA_ONE = {1'b1, {AF{1'b0}}};

  tcm_pkg::state_t  state_r, state_nxt;
  tcm_pkg::kind_t   kind_r, kind_nxt;
  tcm_pkg::status_t res_stat_r, res_stat_nxt;
  tcm_pkg::status_t out_stat_r, out_stat_nxt;

  logic                 inv_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic                 shift_r, shift_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]        chk_idx_r, chk_idx_nxt;
  logic [IW-1:0]        ins_idx_r, ins_idx_nxt;
  logic signed [VB-1:0] v_r, v_nxt;
  logic signed [VB-1:0] prev_r, prev_nxt;
  logic signed [VB-1:0] p0_r, p0_nxt;
  logic signed [VB-1:0] p1_r, p1_nxt;
  logic [VB-1:0]        span_r, span_nxt;
  logic [VB-1:0]        res_val_r, res_val_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VB-1:0]        out_val_r, out_val_nxt;
  logic [tcm_pkg::HELD_BITS-1:0] out_held_r, out_held_nxt;

  logic                 in_acc;
  logic                 out_load;
  logic                 ram_wr_en, ram_rd_en;
  logic [IW-1:0]        ram_wr_addr, ram_rd_addr;
  logic signed [VB-1:0] ram_wr_data, ram_rd_data;
  logic                 div_start, div_done;
  logic [AF-1:0]        div_quot;
  logic                 mul_start, mul_done;
  logic [AF:0]          alpha;
  logic [VB-1:0]        mul_mag;
  logic                 hit, eq, lt, last;
  logic [IW-1:0]        chk_up;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign hit      = v_r < ram_rd_data;
  assign eq       = ram_rd_data == v_r;
  assign lt       = ram_rd_data < v_r;
  assign last     = CW'(chk_idx_r) == (count_r - CW'(1));
  assign chk_up   = chk_idx_r + IW'(1);
  assign out_load = (state_r == tcm_pkg::S_DONE) && (!out_valid_r || out_ch.ready);
  assign alpha    = inv_r ? (ALPHA_ONE - {1'b0, div_quot}) : {1'b0, div_quot};

  tcm_point_ram #(.DEPTH(MAX_POINTS), .WIDTH(VB)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tcm_divider #(.VALUE_BITS(VB)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .numer_i (VB'(v_r - prev_r)),
    .denom_i (VB'(ram_rd_data - prev_r)),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  tcm_scaler #(.VALUE_BITS(VB)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .alpha_i (alpha),
    .span_i  (span_r),
    .done_o  (mul_done),
    .mag_o   (mul_mag)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcm_pkg::S_IDLE: begin
        if (in_acc) begin
          case (tcm_pkg::kind_t'(in_ch.kind))
            tcm_pkg::KIND_EVAL: begin
              state_nxt = (count_r < CW'(2)) ? tcm_pkg::S_DONE : tcm_pkg::S_SCAN;
            end
            tcm_pkg::KIND_ADD: begin
              if (count_r >= CW'(MAX_POINTS)) begin
                state_nxt = tcm_pkg::S_DONE;
              end else if (count_r == '0) begin
                state_nxt = tcm_pkg::S_WR;
              end else begin
                state_nxt = tcm_pkg::S_SCAN;
              end
            end
            default: state_nxt = tcm_pkg::S_DONE;
          endcase
        end
      end
      tcm_pkg::S_SCAN: begin
        if (chk_vld_r) begin
          if (kind_r == tcm_pkg::KIND_EVAL) begin
            if (hit) begin
              state_nxt = (chk_idx_r == '0) ? tcm_pkg::S_DONE : tcm_pkg::S_DIV;
            end else if (last) begin
              state_nxt = tcm_pkg::S_DONE;
            end
          end else begin
            if (eq) begin
              state_nxt = tcm_pkg::S_DONE;
            end else if (shift_r && (lt || chk_idx_r == '0)) begin
              state_nxt = tcm_pkg::S_WR;
            end
          end
        end
      end
      tcm_pkg::S_WR:  state_nxt = tcm_pkg::S_DONE;
      tcm_pkg::S_DIV: if (div_done) state_nxt = tcm_pkg::S_MUL;
      tcm_pkg::S_MUL: if (mul_done) state_nxt = tcm_pkg::S_DONE;
      tcm_pkg::S_DONE: if (out_load) state_nxt = tcm_pkg::S_IDLE;
      default: state_nxt = tcm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    kind_nxt      = kind_r;
    v_nxt         = v_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    shift_nxt     = shift_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    ins_idx_nxt   = ins_idx_r;
    prev_nxt      = prev_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    span_nxt      = span_r;
    res_val_nxt   = res_val_r;
    res_stat_nxt  = res_stat_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = chk_up;
    ram_wr_data   = ram_rd_data;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_stat_nxt  = out_stat_r;
    out_held_nxt  = out_held_r;
    case (state_r)
      tcm_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_nxt     = tcm_pkg::kind_t'(in_ch.kind);
          v_nxt        = (tcm_pkg::kind_t'(in_ch.kind) == tcm_pkg::KIND_ADD) ?
                         in_ch.point_value : in_ch.sample;
          rem_nxt      = count_r;
          shift_nxt    = 1'b0;
          ins_idx_nxt  = '0;
          res_val_nxt  = '0;
          res_stat_nxt = tcm_pkg::STAT_OK;
          case (tcm_pkg::kind_t'(in_ch.kind))
            tcm_pkg::KIND_EVAL: begin
              if (count_r < CW'(2)) res_stat_nxt = tcm_pkg::STAT_FEW;
            end
            tcm_pkg::KIND_ADD: begin
              if (count_r >= CW'(MAX_POINTS)) res_stat_nxt = tcm_pkg::STAT_FULL;
            end
            tcm_pkg::KIND_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end
      tcm_pkg::S_SCAN: begin
        ram_rd_en   = rem_r != '0;
        ram_rd_addr = (kind_r == tcm_pkg::KIND_EVAL) ? IW'(count_r - rem_r) :
                      IW'(rem_r - CW'(1));
        if (ram_rd_en) begin
          rem_nxt     = rem_r - CW'(1);
          chk_idx_nxt = ram_rd_addr;
        end
        chk_vld_nxt = ram_rd_en && (state_nxt == tcm_pkg::S_SCAN);
        if (chk_vld_r) begin
          if (kind_r == tcm_pkg::KIND_EVAL) begin
            prev_nxt = ram_rd_data;
            if (hit && chk_idx_r != '0) begin
              p0_nxt    = prev_r;
              p1_nxt    = ram_rd_data;
              span_nxt  = VB'(ram_rd_data - prev_r);
              div_start = 1'b1;
            end else if (hit || last) begin
              res_val_nxt = ram_rd_data;
            end
          end else begin
            if (eq) begin
              res_stat_nxt = tcm_pkg::STAT_DUP;
            end else if (!shift_r) begin
              // no duplicate held, rescan from the top and shift entries up
              if (lt || chk_idx_r == '0) begin
                rem_nxt     = count_r;
                shift_nxt   = 1'b1;
                chk_vld_nxt = 1'b0;
              end
            end else if (lt) begin
              ins_idx_nxt = chk_up;
            end else begin
              ram_wr_en   = 1'b1;
              ins_idx_nxt = '0;
            end
          end
        end
      end
      tcm_pkg::S_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = ins_idx_r;
        ram_wr_data = v_r;
        count_nxt   = count_r + CW'(1);
      end
      tcm_pkg::S_DIV: begin
        mul_start = div_done;
      end
      tcm_pkg::S_MUL: begin
        if (mul_done) begin
          res_val_nxt = inv_r ? (p1_r - mul_mag) : (p0_r + mul_mag);
        end
      end
      tcm_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_stat_nxt  = res_stat_r;
          out_held_nxt  = tcm_pkg::HELD_BITS'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcm_pkg::S_IDLE;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      inv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) inv_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    v_r        <= v_nxt;
    rem_r      <= rem_nxt;
    shift_r    <= shift_nxt;
    chk_idx_r  <= chk_idx_nxt;
    ins_idx_r  <= ins_idx_nxt;
    prev_r     <= prev_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    span_r     <= span_nxt;
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_held_r <= out_held_nxt;
  end

  assign in_ch.ready         = state_r == tcm_pkg::S_IDLE;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.mapped_value = out_val_r;
  assign out_ch.status       = out_stat_r;
  assign out_ch.points_held  = out_held_r;

  `TCM_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_r <= CW'(MAX_POINTS))
  `TCM_ASSERT_NOW(a_wr_in_table, clk, rst_n, ram_wr_en, CW'(ram_wr_addr) <= count_r)
  `TCM_ASSERT_NOW(a_wr_states, clk, rst_n, ram_wr_en,
                  state_r == tcm_pkg::S_SCAN || state_r == tcm_pkg::S_WR)
  `TCM_ASSERT_NEXT(a_clear_empties, clk, rst_n, in_acc && in_ch.kind == tcm_pkg::KIND_CLEAR, count_r == '0)

endmodule

`default_nettype wire

// ----- tb/sv/terrace_curve_mapper_core_tb.sv -----
// self-checking testbench of the terrace curve mapper: directed table, then random sequences
`default_nettype none

module terrace_curve_mapper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = tcm_pkg::MAX_POINTS_DEF;
  localparam int VB = tcm_pkg::VALUE_BITS_DEF;
  localparam int KB = tcm_pkg::KIND_BITS;
  localparam int HB = tcm_pkg::HELD_BITS;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 250;
  localparam int TAIL_CYCLES = 40;
  localparam logic [KB-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic signed [VB-1:0] mapped;
    tcm_pkg::status_t status;
    logic [HB-1:0] held;
  } result_t;

  typedef struct packed {
    logic [KB-1:0] kind;
    logic signed [VB-1:0] sample;
    logic signed [VB-1:0] pv;
    logic typed;
    result_t res;
  } dir_row_t;

  localparam int DIR_ROWS_N = 23;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{tcm_pkg::KIND_EVAL, 16'sh0000, 16'sh0000, 1'b1, '{16'sh0000, tcm_pkg::STAT_FEW, 5'd0}},
    '{tcm_pkg::KIND_ADD, 16'sh0000, 16'sh0000, 1'b1, '{16'sh0000, tcm_pkg::STAT_OK, 5'd1}},
    '{tcm_pkg::KIND_EVAL, 16'sh1234, 16'sh0000, 1'b1, '{16'sh0000, tcm_pkg::STAT_FEW, 5'd1}},
    '{tcm_pkg::KIND_ADD, 16'sh0000, 16'sh8000, 1'b1, '{16'sh0000, tcm_pkg::STAT_OK, 5'd2}},
    '{tcm_pkg::KIND_ADD, 16'sh0000, 16'sh7fff, 1'b1, '{16'sh0000, tcm_pkg::STAT_OK, 5'd3}},
    '{tcm_pkg::KIND_ADD, 16'sh0000, 16'sh0000, 1'b1, '{16'sh0000, tcm_pkg::STAT_DUP, 5'd3}},
    '{tcm_pkg::KIND_EVAL, 16'sh8000, 16'sh0000, 1'b0, '0},
    '{tcm_pkg::KIND_EVAL, 16'sh7fff, 16'sh0000, 1'b1, '{16'sh7fff, tcm_pkg::STAT_OK, 5'd3}},
    '{tcm_pkg::KIND_EVAL, 16'sh4000, 16'sh0000, 1'b0, '0},
    '{tcm_pkg::KIND_EVAL, 16'shffff, 16'sh0000, 1'b0, '0},
    '{tcm_pkg::KIND_EVAL, 16'sh0000, 16'sh0000, 1'b0, '0},
    '{KIND_SPARE, 16'sh7fff, 16'sh7fff, 1'b1, '{16'sh0000, tcm_pkg::STAT_OK, 5'd3}},
    '{tcm_pkg::KIND_ADD, 16'sh0000, 16'sh0001, 1'b1, '{16'sh0000, tcm_pkg::STAT_OK, 5'd4}},
    '{tcm_pkg::KIND_EVAL, 16'sh0001, 16'sh0000, 1'b0, '0},
    '{tcm_pkg::KIND_CLEAR, 16'sh0000, 16'sh0000, 1'b1, '{16'sh0000, tcm_pkg::STAT_OK, 5'd0}},
    '{tcm_pkg::KIND_EVAL, 16'sh7fff, 16'sh0000, 1'b1, '{16'sh0000, tcm_pkg::STAT_FEW, 5'd0}},
    '{tcm_pkg::KIND_ADD, 16'sh0000, 16'sh0100, 1'b1, '{16'sh0000, tcm_pkg::STAT_OK, 5'd1}},
    '{tcm_pkg::KIND_ADD, 16'sh0000, 16'shff00, 1'b1, '{16'sh0000, tcm_pkg::STAT_OK, 5'd2}},
    '{tcm_pkg::KIND_EVAL, 16'sh8000, 16'sh0000, 1'b1, '{16'shff00, tcm_pkg::STAT_OK, 5'd2}},
    '{tcm_pkg::KIND_EVAL, 16'sh0100, 16'sh0000, 1'b1, '{16'sh0100, tcm_pkg::STAT_OK, 5'd2}},
    '{tcm_pkg::KIND_EVAL, 16'sh0000, 16'sh0000, 1'b0, '0},
    '{tcm_pkg::KIND_EVAL, 16'sh00ff, 16'sh0000, 1'b0, '0},
    '{tcm_pkg::KIND_CLEAR, 16'sh0000, 16'sh0000, 1'b1, '{16'sh0000, tcm_pkg::STAT_OK, 5'd0}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  int unsigned cycle_cnt = 0;
  int err_cnt = 0;
  int accepted_items = 0;

  logic signed [VB-1:0] pt_tab [NPTS];
  int unsigned pt_cnt;
  bit invert_mode;
  result_t pending_results [$];

  wire calm = (cycle_cnt % 5000) < 1500;

  tcm_in_if #(.VALUE_BITS(VB)) in_ch ();
  tcm_out_if #(.VALUE_BITS(VB)) out_ch ();

  terrace_curve_mapper_core #(
    .MAX_POINTS(NPTS),
    .VALUE_BITS(VB)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic logic signed [VB-1:0] rnd16();
    return VB'($urandom);
  endfunction

  function automatic logic signed [VB-1:0] terrace_eval(logic signed [VB-1:0] v);
    int unsigned pos, i0, i1;
    longint p0, p1;
    longint unsigned d, n, alpha, a2, m;
    pos = 0;
    while (pos < pt_cnt && !(v < pt_tab[pos])) pos++;
    i0 = (pos == 0) ? 0 : pos - 1;
    i1 = (pos > pt_cnt - 1) ? pt_cnt - 1 : pos;
    if (i0 == i1) return pt_tab[i1];
    p0 = pt_tab[i0];
    p1 = pt_tab[i1];
    d = p1 - p0;
    n = longint'(v) - p0;
    if (n >= d) n = d - 1;
    alpha = (n << 16) / d;
    if (invert_mode) alpha = 64'd65536 - alpha;
    a2 = (alpha * alpha) >> 16;
    m = (d * a2 + 64'd32768) >> 16;
    return VB'(invert_mode ? p1 - longint'(m) : p0 + longint'(m));
  endfunction

  function automatic tcm_pkg::status_t insert_point(logic signed [VB-1:0] pv);
    int unsigned pos;
    if (pt_cnt >= NPTS) return tcm_pkg::STAT_FULL;
    for (int unsigned k = 0; k < pt_cnt; k++)
      if (pt_tab[k] == pv) return tcm_pkg::STAT_DUP;
    pos = 0;
    while (pos < pt_cnt && pt_tab[pos] < pv) pos++;
    for (int unsigned k = pt_cnt; k > pos; k--) pt_tab[k] = pt_tab[k-1];
    pt_tab[pos] = pv;
    pt_cnt++;
    return tcm_pkg::STAT_OK;
  endfunction

  function automatic result_t predict_item(logic [KB-1:0] kind,
                                           logic signed [VB-1:0] sample,
                                           logic signed [VB-1:0] pv);
    result_t r;
    r = '0;
    r.status = tcm_pkg::STAT_OK;
    case (kind)
      tcm_pkg::KIND_EVAL: begin
        if (pt_cnt < 2) r.status = tcm_pkg::STAT_FEW;
        else r.mapped = terrace_eval(sample);
      end
      tcm_pkg::KIND_ADD: begin
        r.status = insert_point(pv);
      end
      tcm_pkg::KIND_CLEAR: begin
        pt_cnt = 0;
      end
      default: begin
      end
    endcase
    r.held = HB'(pt_cnt);
    return r;
  endfunction

  task automatic send_item(input logic [KB-1:0] kind,
                           input logic signed [VB-1:0] sample,
                           input logic signed [VB-1:0] pv,
                           input bit given_ok,
                           input result_t given);
    result_t want;
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.sample <= sample;
    in_ch.point_value <= pv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = predict_item(kind, sample, pv);
    if (given_ok) want = given;
    pending_results = {pending_results, want};
    accepted_items++;
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic set_invert(input bit v);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    invert_mode = v;
  endtask

  task automatic run_table();
    dir_row_t row;
    for (int i = 0; i < DIR_ROWS_N; i++) begin
      row = DIR_ROWS[i];
      send_item(row.kind,
                (row.kind == tcm_pkg::KIND_EVAL) ? row.sample : rnd16(),
                (row.kind == tcm_pkg::KIND_ADD) ? row.pv : rnd16(),
                row.typed, row.res);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic run_random_items(input int target);
    int n_pts, n_ev, mode, pick;
    logic signed [VB-1:0] v;
    while (accepted_items < target) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 3) != 0)
          send_item(tcm_pkg::KIND_CLEAR, rnd16(), rnd16(), 1'b0, '0);
        n_pts = $urandom_range(2, 18);
        mode = $urandom_range(0, 2);
        repeat (n_pts) begin
          case (mode)
            0: v = rnd16();
            1: v = VB'($urandom_range(0, 31)) - 16'sd16;
            default: v = ($urandom_range(0, 1) ? 16'sh7ff0 : 16'sh8000) +
                         VB'($urandom_range(0, 15));
          endcase
          send_item(tcm_pkg::KIND_ADD, rnd16(), v, 1'b0, '0);
        end
        n_ev = $urandom_range(1, 12);
        repeat (n_ev) begin
          pick = $urandom_range(0, 9);
          if (pick < 4 || pt_cnt == 0) v = rnd16();
          else if (pick < 8)
            v = pt_tab[$urandom_range(0, pt_cnt - 1)] + VB'($urandom_range(0, 6)) - 16'sd3;
          else v = (pick == 8) ? 16'sh8000 : 16'sh7fff;
          send_item(tcm_pkg::KIND_EVAL, v, rnd16(), 1'b0, '0);
        end
      end else begin
        // noise, sometimes re-adding a held point
        if (pt_cnt > 0 && $urandom_range(0, 1)) v = pt_tab[$urandom_range(0, pt_cnt - 1)];
        else v = rnd16();
        send_item(KB'($urandom_range(0, 3)), rnd16(), v, 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: mapped_value %0d status %0d points_held %0d",
               out_ch.mapped_value, out_ch.status, out_ch.points_held);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.mapped_value !== want.mapped) begin
          $error("mapped_value mismatch: expected %0d, actual %0d",
                 want.mapped, out_ch.mapped_value);
          err_cnt++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
          err_cnt++;
        end
        if (out_ch.points_held !== want.held) begin
          $error("points_held mismatch: expected %0d, actual %0d",
                 want.held, out_ch.points_held);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = tcm_pkg::KIND_EVAL;
    in_ch.sample = '0;
    in_ch.point_value = '0;
    pt_cnt = 0;
    invert_mode = 1'b0;
    for (int i = 0; i < NPTS; i++) pt_tab[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_table();
    set_invert(1'b1);
    run_table();

    for (int ph = 0; ph < 6; ph++) begin
      set_invert(ph % 2 != 0);
      run_random_items(accepted_items + PHASE_ITEMS);
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/tcm_pkg.sv
hdl/tcm_channels.sv
hdl/tcm_point_ram.sv
hdl/tcm_divider.sv
hdl/tcm_scaler.sv
hdl/terrace_curve_mapper_core.sv
tb/sv/terrace_curve_mapper_core_tb.sv
